/* src/point_grid_gradient_classifier_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the point grid gradient classifier
// Shared wrappers so that every check reports through $error in one form.
// ----------------------------------------------------------------------------
`ifndef POINT_GRID_GRADIENT_CLASSIFIER_ASSERT_SVH
`define POINT_GRID_GRADIENT_CLASSIFIER_ASSERT_SVH

// Clocked check that is switched off while reset is held.
`define PGG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check that also covers the cycles around reset.
`define PGG_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

/* src/pgg_pkg.sv */
// ----------------------------------------------------------------------------
// pgg_pkg
// Constants, codes and shared types of the point grid gradient classifier.
// ----------------------------------------------------------------------------
package pgg_pkg;

    // Default grid size and the widest row or column index the grid allows.
    localparam int GRID_ROWS_DEF = 128;
    localparam int GRID_COLS_DEF = 128;
    localparam int IDX_W_MAX     = 10;

    // Depth of the command queue between the front and the back.
    localparam int CMD_Q_DEPTH = 4;

    // Field widths.
    localparam int OP_W    = 2;
    localparam int COORD_W = 16;
    localparam int QIDX_W  = 7;
    localparam int CFG_W   = 4;
    localparam int COUNT_W = 16;
    localparam int DIFF_W  = 17;
    localparam int LEVEL_W = 4;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 64;

    localparam logic [CFG_W-1:0] CELL_LOG2_RST = 4'd7;

    // Operation codes, also used as command kinds in the queue.
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    // Level banding.
    localparam int LEVEL_MAX = 5;
    localparam int DIFF_BAND = 20;
    localparam int MAG_FLOOR = 20;
    localparam int MAG_TOP   = 200;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // Which of the three cells of a query lie inside the grid.
    typedef struct packed {
        logic here;
        logic down;
        logic right;
    } t_cell_ok;

endpackage

/* src/pgg_front.sv */
// ----------------------------------------------------------------------------
// pgg_front
// Accepts input transactions, bins points into grid cells and queues commands.
// ----------------------------------------------------------------------------
module pgg_front #(
    parameter int GRID_ROWS = pgg_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = pgg_pkg::GRID_COLS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pgg_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [pgg_pkg::OP_W-1:0]          i_op,
    input  logic signed [pgg_pkg::COORD_W-1:0] i_x,
    input  logic signed [pgg_pkg::COORD_W-1:0] i_y,
    input  logic [pgg_pkg::QIDX_W-1:0]        i_qrow,
    input  logic [pgg_pkg::QIDX_W-1:0]        i_qcol,
    input  logic                              i_q_full,
    input  logic                              i_init_done,
    output logic                              o_push,
    output logic [pgg_pkg::OP_W+$clog2(GRID_ROWS)+$clog2(GRID_COLS)+2:0] o_entry
);

    localparam int RW    = $clog2(GRID_ROWS);
    localparam int CW    = $clog2(GRID_COLS);
    localparam int SH_W  = pgg_pkg::COORD_W + 1;
    localparam int POS_W = pgg_pkg::COORD_W + 2;
    localparam int QX_W  = pgg_pkg::IDX_W_MAX + 1;

    localparam logic signed [POS_W-1:0] ROWS_S  = POS_W'(GRID_ROWS);
    localparam logic signed [POS_W-1:0] COLS_S  = POS_W'(GRID_COLS);
    localparam logic signed [POS_W-1:0] COL_OFS = POS_W'(GRID_COLS / 2);
    localparam logic [QX_W-1:0]         ROWS_Q  = QX_W'(GRID_ROWS);
    localparam logic [QX_W-1:0]         COLS_Q  = QX_W'(GRID_COLS);

    logic [pgg_pkg::CFG_W-1:0] r_cell_log2;

    logic [SH_W-1:0]         round_add;
    logic signed [SH_W-1:0]  x_sum;
    logic signed [SH_W-1:0]  y_sum;
    logic signed [SH_W-1:0]  x_cell;
    logic signed [SH_W-1:0]  y_cell;
    logic signed [POS_W-1:0] row_s;
    logic signed [POS_W-1:0] col_s;
    logic                    add_ok;
    logic [QX_W-1:0]         q_row;
    logic [QX_W-1:0]         q_col;
    logic [QX_W-1:0]         q_row_n;
    logic [QX_W-1:0]         q_col_n;
    pgg_pkg::t_cell_ok       q_ok;
    logic [RW-1:0]           e_row;
    logic [CW-1:0]           e_col;
    logic                    keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_log2 <= pgg_pkg::CELL_LOG2_RST;
        end else if (i_cfg_we) begin
            r_cell_log2 <= i_cfg_wdata;
        end
    end

    // Ceiling division by the cell edge: add edge-1, then shift arithmetically.
    assign round_add = (SH_W'(1) << r_cell_log2) - SH_W'(1);
    assign x_sum     = $signed({i_x[pgg_pkg::COORD_W-1], i_x}) + $signed(round_add);
    assign y_sum     = $signed({i_y[pgg_pkg::COORD_W-1], i_y}) + $signed(round_add);
    assign x_cell    = x_sum >>> r_cell_log2;
    assign y_cell    = y_sum >>> r_cell_log2;
    assign row_s     = $signed({x_cell[SH_W-1], x_cell});
    assign col_s     = $signed({y_cell[SH_W-1], y_cell}) + COL_OFS;

    assign add_ok = !row_s[POS_W-1] && (row_s < ROWS_S) &&
                    !col_s[POS_W-1] && (col_s < COLS_S);

    assign q_row   = QX_W'(i_qrow);
    assign q_col   = QX_W'(i_qcol);
    assign q_row_n = q_row + QX_W'(1);
    assign q_col_n = q_col + QX_W'(1);

    assign q_ok.here  = (q_row < ROWS_Q) && (q_col < COLS_Q);
    assign q_ok.down  = (q_row_n < ROWS_Q) && (q_col < COLS_Q);
    assign q_ok.right = (q_row < ROWS_Q) && (q_col_n < COLS_Q);

    always_comb begin
        e_row = q_row[RW-1:0];
        e_col = q_col[CW-1:0];
        keep  = 1'b0;
        case (i_op)
            pgg_pkg::OP_CLEAR: begin
                keep = 1'b1;
            end
            pgg_pkg::OP_ADD: begin
                e_row = row_s[RW-1:0];
                e_col = col_s[CW-1:0];
                keep  = add_ok;
            end
            pgg_pkg::OP_QUERY: begin
                keep = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_ready = !i_q_full && i_init_done;
    assign o_push  = i_valid && o_ready && keep;
    assign o_entry = {i_op, e_row, e_col, q_ok};

endmodule

/* src/pgg_fifo.sv */
// ----------------------------------------------------------------------------
// pgg_fifo
// Small register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module pgg_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = pgg_pkg::CMD_Q_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);

    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PW-1:0]     r_wp;
    logic [PW-1:0]     r_rp;
    logic [CNT_W-1:0]  r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

/* src/pgg_back.sv */
// ----------------------------------------------------------------------------
// pgg_back
// Executes queued commands on the count memory and forms query results.
// ----------------------------------------------------------------------------
module pgg_back #(
    parameter int GRID_ROWS = pgg_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = pgg_pkg::GRID_COLS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_empty,
    input  logic [pgg_pkg::OP_W+$clog2(GRID_ROWS)+$clog2(GRID_COLS)+2:0] i_entry,
    output logic                                o_pop,
    output logic                                o_init_done,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [pgg_pkg::DIFF_W-1:0]   o_vdiff,
    output logic signed [pgg_pkg::DIFF_W-1:0]   o_hdiff,
    output logic [pgg_pkg::DIFF_W-1:0]          o_mag,
    output logic signed [pgg_pkg::LEVEL_W-1:0]  o_lvl_v,
    output logic signed [pgg_pkg::LEVEL_W-1:0]  o_lvl_h,
    output logic signed [pgg_pkg::LEVEL_W-1:0]  o_lvl_m
);

    localparam int RW     = $clog2(GRID_ROWS);
    localparam int CW     = $clog2(GRID_COLS);
    localparam int AW     = RW + CW;
    localparam int ENT_W  = pgg_pkg::OP_W + RW + CW + 3;
    localparam int DEPTH  = GRID_ROWS * (1 << CW);
    localparam int DW     = pgg_pkg::DIFF_W;
    localparam int LW     = pgg_pkg::LEVEL_W;
    localparam int CNT_W  = pgg_pkg::COUNT_W;
    localparam int MAG_STEPS = pgg_pkg::MAG_TOP / pgg_pkg::DIFF_BAND;
    localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_CLEAR   = 3'd1;
    localparam logic [2:0] ST_ADD_WR  = 3'd2;
    localparam logic [2:0] ST_Q_DOWN  = 3'd3;
    localparam logic [2:0] ST_Q_RIGHT = 3'd4;
    localparam logic [2:0] ST_Q_DIFF  = 3'd5;
    localparam logic [2:0] ST_Q_OUT   = 3'd6;

    // Positive differences band by floor, negative ones by the ceiling of their magnitude.
    function automatic logic [LW-1:0] diff_level(input logic signed [DW-1:0] d);
        logic [LW-1:0] lv;
        logic [DW-1:0] neg;
        lv  = '0;
        neg = DW'(0) - d;
        if (!d[DW-1]) begin
            for (int i = 1; i <= pgg_pkg::LEVEL_MAX; i++) begin
                if (d >= DW'(pgg_pkg::DIFF_BAND * i)) begin
                    lv = LW'(i);
                end
            end
        end else begin
            lv = LW'(-1);
            for (int i = 1; i < pgg_pkg::LEVEL_MAX; i++) begin
                if (neg > DW'(pgg_pkg::DIFF_BAND * i)) begin
                    lv = LW'(-(i + 1));
                end
            end
        end
        return lv;
    endfunction

    function automatic logic [LW-1:0] mag_level(input logic [DW-1:0] m);
        logic [LW-1:0] lv;
        lv = LW'(-pgg_pkg::LEVEL_MAX);
        if (m >= DW'(pgg_pkg::MAG_FLOOR)) begin
            lv = LW'(1 - pgg_pkg::LEVEL_MAX);
            for (int i = 2; i <= MAG_STEPS; i++) begin
                if (m >= DW'(pgg_pkg::DIFF_BAND * i)) begin
                    lv = LW'(i - pgg_pkg::LEVEL_MAX);
                end
            end
        end
        return lv;
    endfunction

    logic [CNT_W-1:0] r_mem [DEPTH];
    logic [CNT_W-1:0] r_rd_data;

    logic [2:0]        r_state,     n_state;
    logic [AW-1:0]     r_clr_addr,  n_clr_addr;
    logic              r_init_done, n_init_done;
    logic [RW-1:0]     r_row,       n_row;
    logic [CW-1:0]     r_col,       n_col;
    pgg_pkg::t_cell_ok r_ok,        n_ok;
    logic [CNT_W-1:0]  r_here,      n_here;
    logic [CNT_W-1:0]  r_down,      n_down;
    logic signed [DW-1:0] r_dv,     n_dv;
    logic signed [DW-1:0] r_dh,     n_dh;
    logic              r_o_valid,   n_o_valid;
    logic              load_out;

    logic [DW-1:0]     r_o_vdiff;
    logic [DW-1:0]     r_o_hdiff;
    logic [DW-1:0]     r_o_mag;
    logic [LW-1:0]     r_o_lvl_v;
    logic [LW-1:0]     r_o_lvl_h;
    logic [LW-1:0]     r_o_lvl_m;

    logic [pgg_pkg::OP_W-1:0] head_op;
    logic [RW-1:0]     head_row;
    logic [CW-1:0]     head_col;
    pgg_pkg::t_cell_ok head_ok;
    logic [RW-1:0]     row_dn;
    logic [CW-1:0]     col_rt;
    logic [CNT_W-1:0]  right_cnt;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CNT_W-1:0]  mem_wdata;
    logic [AW-1:0]     mem_raddr;

    logic [DW-1:0]     abs_v;
    logic [DW-1:0]     abs_h;
    logic [DW-1:0]     mag;

    assign head_op  = i_entry[ENT_W-1 -: pgg_pkg::OP_W];
    assign head_row = i_entry[CW+3 +: RW];
    assign head_col = i_entry[3 +: CW];
    assign head_ok  = pgg_pkg::t_cell_ok'(i_entry[2:0]);
    assign row_dn   = r_row + RW'(1);
    assign col_rt   = r_col + CW'(1);
    assign right_cnt = r_ok.right ? r_rd_data : '0;

    assign abs_v = r_dv[DW-1] ? DW'(0) - r_dv : r_dv;
    assign abs_h = r_dh[DW-1] ? DW'(0) - r_dh : r_dh;
    assign mag   = abs_v + abs_h;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_init_done = r_init_done;
        n_row       = r_row;
        n_col       = r_col;
        n_ok        = r_ok;
        n_here      = r_here;
        n_down      = r_down;
        n_dv        = r_dv;
        n_dh        = r_dh;
        o_pop       = 1'b0;
        load_out    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = {r_row, r_col};
        mem_wdata   = '0;
        mem_raddr   = {r_row, r_col};
        case (r_state)
            ST_IDLE: begin
                mem_raddr = {head_row, head_col};
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    n_row = head_row;
                    n_col = head_col;
                    n_ok  = head_ok;
                    case (head_op)
                        pgg_pkg::OP_CLEAR: begin
                            n_clr_addr = '0;
                            n_state    = ST_CLEAR;
                        end
                        pgg_pkg::OP_ADD: begin
                            n_state = ST_ADD_WR;
                        end
                        pgg_pkg::OP_QUERY: begin
                            n_state = ST_Q_DOWN;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                if (r_clr_addr == CLR_LAST) begin
                    n_init_done = 1'b1;
                    n_state     = ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + AW'(1);
                end
            end
            ST_ADD_WR: begin
                mem_we    = 1'b1;
                mem_wdata = (r_rd_data == pgg_pkg::COUNT_MAX) ?
                            r_rd_data : r_rd_data + CNT_W'(1);
                n_state   = ST_IDLE;
            end
            ST_Q_DOWN: begin
                mem_raddr = {row_dn, r_col};
                n_here    = r_ok.here ? r_rd_data : '0;
                n_state   = ST_Q_RIGHT;
            end
            ST_Q_RIGHT: begin
                mem_raddr = {r_row, col_rt};
                n_down    = r_ok.down ? r_rd_data : '0;
                n_state   = ST_Q_DIFF;
            end
            ST_Q_DIFF: begin
                n_dv    = $signed({1'b0, r_down}) - $signed({1'b0, r_here});
                n_dh    = $signed({1'b0, right_cnt}) - $signed({1'b0, r_here});
                n_state = ST_Q_OUT;
            end
            ST_Q_OUT: begin
                if (!r_o_valid || i_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_o_valid = r_o_valid && !i_ready;
        if (load_out) begin
            n_o_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_init_done <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_init_done <= n_init_done;
            r_o_valid   <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row  <= n_row;
        r_col  <= n_col;
        r_ok   <= n_ok;
        r_here <= n_here;
        r_down <= n_down;
        r_dv   <= n_dv;
        r_dh   <= n_dh;
        if (load_out) begin
            r_o_vdiff <= r_dv;
            r_o_hdiff <= r_dh;
            r_o_mag   <= mag;
            r_o_lvl_v <= diff_level(r_dv);
            r_o_lvl_h <= diff_level(r_dh);
            r_o_lvl_m <= mag_level(mag);
        end
    end

    assign o_init_done = r_init_done;
    assign o_valid     = r_o_valid;
    assign o_vdiff     = $signed(r_o_vdiff);
    assign o_hdiff     = $signed(r_o_hdiff);
    assign o_mag       = r_o_mag;
    assign o_lvl_v     = $signed(r_o_lvl_v);
    assign o_lvl_h     = $signed(r_o_lvl_h);
    assign o_lvl_m     = $signed(r_o_lvl_m);

endmodule

/* src/point_grid_gradient_classifier.sv */
// ----------------------------------------------------------------------------
// point_grid_gradient_classifier
// Bins 2D points into a grid of saturating counts and reports the forward
// gradient of any cell. After reset the count memory is swept to zero, one
// entry per cycle, through all GRID_ROWS * 2**clog2(GRID_COLS) entries
// (16384 at the default size), and no transaction is accepted until the
// sweep is over. A clear transaction runs the same sweep. The front bins
// each point in the cycle it is accepted and queues a command; points
// outside the grid and unused operation codes are dropped there. The back
// owns the single count memory with one write port and one registered read
// port: an add is a read followed by a write; a query reads its three
// cells one after the other, forms the differences and then loads the
// result register; a clear writes zero to every memory entry in turn. A
// four-entry command queue lets the input keep flowing while the back is
// busy or the result register waits for the consumer.
// ----------------------------------------------------------------------------
module point_grid_gradient_classifier #(
    parameter int GRID_ROWS = pgg_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = pgg_pkg::GRID_COLS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // Cell edge log2, written whenever the enable is high.
    input  logic                                i_cfg_we,
    input  logic [pgg_pkg::CFG_W-1:0]           i_cfg_wdata,

    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // point_x [15:0], point_y [31:16], query_row [38:32], query_col [45:39],
    // zero [47:46]
    input  logic [pgg_pkg::IN_DATA_W-1:0]       i_s_axis_tdata,
    // operation [1:0]
    input  logic [pgg_pkg::OP_W-1:0]            i_s_axis_tuser,

    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // vertical_diff [16:0], horizontal_diff [33:17], magnitude [50:34],
    // level_vertical [54:51], level_horizontal [58:55],
    // level_magnitude [62:59], zero [63]
    output logic [pgg_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata
);

    localparam int RW    = $clog2(GRID_ROWS);
    localparam int CW    = $clog2(GRID_COLS);
    localparam int ENT_W = pgg_pkg::OP_W + RW + CW + 3;
    localparam int DW    = pgg_pkg::DIFF_W;
    localparam int LW    = pgg_pkg::LEVEL_W;

    // Input payload unpacked from the slave-side transaction.
    logic signed [pgg_pkg::COORD_W-1:0] in_x;
    logic signed [pgg_pkg::COORD_W-1:0] in_y;
    logic [pgg_pkg::QIDX_W-1:0]         in_qrow;
    logic [pgg_pkg::QIDX_W-1:0]         in_qcol;

    // Command queue between the two halves.
    logic             q_push;
    logic [ENT_W-1:0] q_wdata;
    logic             q_full;
    logic             q_pop;
    logic [ENT_W-1:0] q_rdata;
    logic             q_empty;
    logic             init_done;

    // Result fields from the back's output register.
    logic signed [DW-1:0] res_vdiff;
    logic signed [DW-1:0] res_hdiff;
    logic [DW-1:0]        res_mag;
    logic signed [LW-1:0] res_lvl_v;
    logic signed [LW-1:0] res_lvl_h;
    logic signed [LW-1:0] res_lvl_m;

    assign in_x    = $signed(i_s_axis_tdata[15:0]);
    assign in_y    = $signed(i_s_axis_tdata[31:16]);
    assign in_qrow = i_s_axis_tdata[38:32];
    assign in_qcol = i_s_axis_tdata[45:39];

    // Front: takes a transaction whenever the queue has room and the
    // memory sweep after reset is done.
    pgg_front #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_op        (i_s_axis_tuser),
        .i_x         (in_x),
        .i_y         (in_y),
        .i_qrow      (in_qrow),
        .i_qcol      (in_qcol),
        .i_q_full    (q_full),
        .i_init_done (init_done),
        .o_push      (q_push),
        .o_entry     (q_wdata)
    );

    pgg_fifo #(
        .DATA_W (ENT_W),
        .DEPTH  (pgg_pkg::CMD_Q_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    // Back: owns the count memory and the result register; a finished
    // query waits only if the previous result has not been taken yet.
    pgg_back #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_entry     (q_rdata),
        .o_pop       (q_pop),
        .o_init_done (init_done),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_vdiff     (res_vdiff),
        .o_hdiff     (res_hdiff),
        .o_mag       (res_mag),
        .o_lvl_v     (res_lvl_v),
        .o_lvl_h     (res_lvl_h),
        .o_lvl_m     (res_lvl_m)
    );

    assign o_m_axis_tdata = {1'b0, res_lvl_m, res_lvl_h, res_lvl_v,
                             res_mag, res_hdiff, res_vdiff};

endmodule

/* src/pgg_checker.sv */
// ----------------------------------------------------------------------------
// pgg_checker
// Port-level checks of the point grid gradient classifier, bound to the top.
// ----------------------------------------------------------------------------
`include "point_grid_gradient_classifier_assert.svh"

module pgg_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [pgg_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata
);

    logic [16:0]        dv;
    logic [16:0]        dh;
    logic [16:0]        mag;
    logic [16:0]        abs_v;
    logic [16:0]        abs_h;
    logic [16:0]        mag_sum;
    logic signed [3:0]  lv;
    logic signed [3:0]  lh;
    logic signed [3:0]  lm;

    assign dv      = o_m_axis_tdata[16:0];
    assign dh      = o_m_axis_tdata[33:17];
    assign mag     = o_m_axis_tdata[50:34];
    assign lv      = $signed(o_m_axis_tdata[54:51]);
    assign lh      = $signed(o_m_axis_tdata[58:55]);
    assign lm      = $signed(o_m_axis_tdata[62:59]);
    assign abs_v   = dv[16] ? 17'd0 - dv : dv;
    assign abs_h   = dh[16] ? 17'd0 - dh : dh;
    assign mag_sum = abs_v + abs_h;

    // A result that is offered stays offered until it is taken.
    `PGG_ASSERT(a_out_hold, i_clk, i_rst_n, (o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid), "result dropped while stalled")

    // The magnitude is always the L1 sum of the two differences shown.
    `PGG_ASSERT(a_mag_sum, i_clk, i_rst_n, (o_m_axis_tvalid |-> (mag == mag_sum)), "magnitude does not match differences")

    // Every level lies between minus five and five.
    `PGG_ASSERT(a_lvl_range, i_clk, i_rst_n, (o_m_axis_tvalid |-> ((lv <= 4'sd5) && (lv >= -4'sd5) && (lh <= 4'sd5) && (lh >= -4'sd5) && (lm <= 4'sd5) && (lm >= -4'sd5))), "level out of range")

    // Right after reset no result is pending and input is held off for the memory sweep.
    `PGG_ASSERT_RST(a_rst_quiet, i_clk, (!i_rst_n |=> (!o_m_axis_tvalid && !o_s_axis_tready)), "block active right after reset")

endmodule

bind point_grid_gradient_classifier pgg_checker u_pgg_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
